// ===== rtl/lmfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the LED matrix frame scan driver.
// No dependencies; every other file of the block refers to this package.
package lmfs_pkg;

    localparam int OPCODE_W    = 2;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int COLOR_W     = 24;
    localparam int LEVEL_W     = 4;
    localparam int DRIVE_W     = 24;
    localparam int ENABLE_W    = 8;
    localparam int DOT_MAX_W   = 24;   // three nibbles of at most 8 bits
    localparam int CHAN_W      = 8;    // one channel of a 24-bit RGB color
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_DOT12 = 2'd0,
        OP_DOT24 = 2'd1,
        OP_FILL  = 2'd2,
        OP_SCAN  = 2'd3
    } t_opcode;

    // Classified command handed from the front end to the frame engine.
    typedef struct packed {
        t_opcode              op;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 row_ok;
        logic                 dot_ok;
        logic                 clear;
        logic [DOT_MAX_W-1:0] dot;
        logic [LEVEL_W-1:0]   level;
    } t_cmd;

endpackage

// ===== rtl/lmfs_in_if.sv =====
`timescale 1ns / 1ps
// Command channel of the LED matrix frame scan driver: valid/ready plus payload.
// Depends on lmfs_pkg for field widths.
interface lmfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [lmfs_pkg::OPCODE_W-1:0] opcode;
    logic [lmfs_pkg::ROW_W-1:0]    row;
    logic [lmfs_pkg::COL_W-1:0]    col;
    logic [lmfs_pkg::COLOR_W-1:0]  color;
    logic                          clear_others;
    logic [lmfs_pkg::LEVEL_W-1:0]  level;

    modport source (output valid, opcode, row, col, color, clear_others, level,
                    input ready);
    modport sink   (input valid, opcode, row, col, color, clear_others, level,
                    output ready);
endinterface

// ===== rtl/lmfs_out_if.sv =====
`timescale 1ns / 1ps
// Scan result channel of the LED matrix frame scan driver: valid/ready plus payload.
// Depends on lmfs_pkg for field widths.
interface lmfs_out_if;
    logic                           valid;
    logic                           ready;
    logic [lmfs_pkg::DRIVE_W-1:0]   drive_bits;
    logic [lmfs_pkg::ENABLE_W-1:0]  line_enable;

    modport source (output valid, drive_bits, line_enable, input ready);
    modport sink   (input valid, drive_bits, line_enable, output ready);
endinterface

// ===== rtl/lmfs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts commands, checks coordinates and converts colors to dots.
// Depends on lmfs_pkg and lmfs_in_if.
module lmfs_front #(
    parameter int ROWS        = 8,
    parameter int COLS        = 8,
    parameter int NIBBLE_BITS = 4
) (
    lmfs_in_if.sink         i_cmd,
    input  logic            i_q_ready,
    output logic            o_push,
    output lmfs_pkg::t_cmd  o_cmd
);

    localparam int DOTW = 3 * NIBBLE_BITS;

    logic [DOTW-1:0] rgb_dot;
    lmfs_pkg::t_opcode op;

    assign op          = lmfs_pkg::t_opcode'(i_cmd.opcode);
    assign i_cmd.ready = i_q_ready;
    assign o_push      = i_cmd.valid && i_q_ready;

    // Keep the top nibble of each 8-bit channel, pack as blue, green, red.
    assign rgb_dot = {i_cmd.color[lmfs_pkg::CHAN_W-1 -: NIBBLE_BITS],
                      i_cmd.color[2*lmfs_pkg::CHAN_W-1 -: NIBBLE_BITS],
                      i_cmd.color[3*lmfs_pkg::CHAN_W-1 -: NIBBLE_BITS]};

    always_comb begin
        o_cmd.op     = op;
        o_cmd.row    = i_cmd.row;
        o_cmd.col    = i_cmd.col;
        o_cmd.row_ok = 32'(i_cmd.row) < ROWS;
        o_cmd.dot_ok = (32'(i_cmd.row) < ROWS) && (32'(i_cmd.col) < COLS);
        o_cmd.clear  = (op == lmfs_pkg::OP_DOT12) && i_cmd.clear_others;
        o_cmd.level  = i_cmd.level;
        case (op)
            lmfs_pkg::OP_DOT12,
            lmfs_pkg::OP_FILL:  o_cmd.dot = lmfs_pkg::DOT_MAX_W'(i_cmd.color[DOTW-1:0]);
            lmfs_pkg::OP_DOT24: o_cmd.dot = lmfs_pkg::DOT_MAX_W'(rgb_dot);
            default:            o_cmd.dot = '0;
        endcase
    end

endmodule

// ===== rtl/lmfs_cmd_queue.sv =====
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the frame engine.
// Depends on lmfs_pkg for the command type and depth.
module lmfs_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmfs_pkg::t_cmd  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output lmfs_pkg::t_cmd  o_data,
    input  logic            i_pop
);

    localparam int PW = $clog2(lmfs_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(lmfs_pkg::QUEUE_DEPTH + 1);

    lmfs_pkg::t_cmd r_mem [lmfs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_ready = r_count != CW'(lmfs_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == lmfs_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == lmfs_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lmfs_back.sv =====
`timescale 1ns / 1ps
// Frame engine: holds the frame, applies writes and fills, and scans lines.
// Depends on lmfs_pkg and lmfs_out_if.
module lmfs_back #(
    parameter int ROWS        = 8,
    parameter int COLS        = 8,
    parameter int NIBBLE_BITS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  lmfs_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    lmfs_out_if.source      o_scan
);

    localparam int DOTW  = 3 * NIBBLE_BITS;
    localparam int LINEW = COLS * DOTW;
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLS);
    localparam int CMPW  = (NIBBLE_BITS > lmfs_pkg::LEVEL_W) ? NIBBLE_BITS
                                                             : lmfs_pkg::LEVEL_W;

    logic [LINEW-1:0]                r_frame [ROWS];
    logic [LINEW-1:0]                n_frame [ROWS];
    logic                            r_out_valid;
    logic [lmfs_pkg::DRIVE_W-1:0]    r_drive;
    logic [lmfs_pkg::ENABLE_W-1:0]   r_enable;
    logic [RW-1:0]                   row_idx;
    logic [CLW-1:0]                  col_idx;
    logic [LINEW-1:0]                line_data;
    logic [lmfs_pkg::DRIVE_W-1:0]    scan_bits;
    logic                            is_scan;

    assign row_idx = RW'(i_q_cmd.row);
    assign col_idx = CLW'(i_q_cmd.col);
    assign is_scan = i_q_cmd.op == lmfs_pkg::OP_SCAN;

    // A scan needs a free output register; writes always go.
    assign o_q_pop = i_q_valid && (!is_scan || !r_out_valid || o_scan.ready);

    assign line_data = i_q_cmd.row_ok ? r_frame[row_idx] : '0;

    // Drive bit order from the top: green, red, blue, each over columns.
    for (genvar s = 0; s < lmfs_pkg::DRIVE_W; s++) begin : g_drive
        localparam int CH  = s / COLS;
        localparam int COL = s % COLS;
        localparam int SH  = (CH == 0) ? NIBBLE_BITS : ((CH == 1) ? 0 : 2 * NIBBLE_BITS);
        if (CH < 3) begin : g_bit
            assign scan_bits[lmfs_pkg::DRIVE_W-1-s] =
                CMPW'(line_data[COL*DOTW + SH +: NIBBLE_BITS]) > CMPW'(i_q_cmd.level);
        end else begin : g_zero
            assign scan_bits[lmfs_pkg::DRIVE_W-1-s] = 1'b0;
        end
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            n_frame[r] = r_frame[r];
        end
        if (o_q_pop) begin
            case (i_q_cmd.op)
                lmfs_pkg::OP_DOT12,
                lmfs_pkg::OP_DOT24: begin
                    if (i_q_cmd.clear) begin
                        for (int r = 0; r < ROWS; r++) begin
                            n_frame[r] = '0;
                        end
                    end
                    if (i_q_cmd.dot_ok) begin
                        n_frame[row_idx][col_idx*DOTW +: DOTW] = i_q_cmd.dot[DOTW-1:0];
                    end
                end
                lmfs_pkg::OP_FILL: begin
                    for (int r = 0; r < ROWS; r++) begin
                        n_frame[r] = {COLS{i_q_cmd.dot[DOTW-1:0]}};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= n_frame[r];
            end
            if (o_q_pop && is_scan) begin
                r_out_valid <= 1'b1;
            end else if (o_scan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_scan) begin
            r_drive  <= scan_bits;
            r_enable <= i_q_cmd.row_ok
                      ? lmfs_pkg::ENABLE_W'(1) << i_q_cmd.row : '0;
        end
    end

    assign o_scan.valid       = r_out_valid;
    assign o_scan.drive_bits  = r_drive;
    assign o_scan.line_enable = r_enable;

    a_scan_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && is_scan) |=> r_out_valid)
        else $error("scan popped but no result raised");

    a_fill_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_cmd.op == lmfs_pkg::OP_FILL)
        |=> r_frame[0][DOTW-1:0] == $past(i_q_cmd.dot[DOTW-1:0]))
        else $error("fill did not reach the frame");

    a_off_row_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && is_scan && !i_q_cmd.row_ok) |=> (r_drive == '0 && r_enable == '0))
        else $error("scan of a missing line drove the matrix");

endmodule

// ===== rtl/led_matrix_frame_scan_driver_unit.sv =====
`timescale 1ns / 1ps
// Top level of the LED matrix frame scan driver.
// Depends on lmfs_pkg, lmfs_in_if, lmfs_out_if, lmfs_front, lmfs_cmd_queue, lmfs_back.
//
// The block keeps a ROWS x COLS frame of dots in flip-flops, each dot three
// NIBBLE_BITS-wide nibbles packed blue, green, red (0xBGR at the default width),
// all cleared by reset. Commands arrive on i_cmd: write one dot from a 12-bit
// color (optionally clearing the frame first), write one dot from 24-bit RGB
// (top nibble of each channel kept), fill the whole frame, or scan one line.
// Only a scan returns a transaction on o_scan: 24 drive bits (bit 23 shifted
// first; green of columns 0..7, then red, then blue; a bit is set when its
// nibble exceeds level) and a one-hot line enable. A line or column beyond the
// frame leaves a dot write undone (a requested clear still happens); a line
// beyond the frame makes a scan return all zeros. Every command is applied as
// the frame engine pops it, so the block sustains one transaction per cycle
// while o_scan keeps up; a scan result passes through the command queue and
// then the output register. The two-entry command queue lets writes keep flowing
// into the engine while a scan result waits on o_scan; i_cmd stalls only once
// the queue is full behind a held result.
module led_matrix_frame_scan_driver_unit #(
    parameter int ROWS        = 8,
    parameter int COLS        = 8,
    parameter int NIBBLE_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmfs_in_if.sink     i_cmd,
    lmfs_out_if.source  o_scan
);

    logic            push;
    logic            q_ready;
    lmfs_pkg::t_cmd  front_cmd;
    logic            q_valid;
    lmfs_pkg::t_cmd  q_cmd;
    logic            q_pop;

    // Classify and convert each command as it is accepted.
    lmfs_front #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .NIBBLE_BITS (NIBBLE_BITS)
    ) u_front (
        .i_cmd     (i_cmd),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    // Hold commands between the front end and the frame engine.
    lmfs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    // Apply writes to the frame and produce scan results in order.
    lmfs_back #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .NIBBLE_BITS (NIBBLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_scan    (o_scan)
    );

endmodule
